>>> rtl/fbmd_pkg.sv
// Shared types, codes and helper functions of the frame store block.
package fbmd_pkg;

   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = 3 * CHAN_W;
   localparam int RES_W   = 9;             // resolution register and in-bounds coordinate
   localparam int COORD_W = 11;            // signed working coordinate, covers x +/- 511
   localparam int STEP_W  = 4;
   localparam logic [STEP_W-1:0] LAST_STEP = 4'd8;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE    = 2'd0,
      OP_READ     = 2'd1,
      OP_FILL     = 2'd2,
      OP_CONTRAST = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_RD,
      ST_CTR,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OFF_ZERO,
      OFF_NEG,
      OFF_POS
   } offset_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic                we;
      logic                re;
      logic [RES_W-1:0]    x;
      logic [RES_W-1:0]    y;
      logic [PIXEL_W-1:0]  wdata;
   } mem_req_type;

   typedef struct packed {
      logic clear;       // new item taken, reset the running maximum
      logic cap_center;  // read data of this cycle is the center pixel
      logic center_ok;   // center lies inside the resolution
      logic cap_nb;      // read data of this cycle is a valid neighbor
      logic load;        // move the finished result into the output register
      logic kind;        // 1 for a contrast result
   } ctl_type;

   // neighbor order: center first, then the eight around it
   function automatic offset_type nb_dx(input logic [STEP_W-1:0] step);
      offset_type r;
      case (step)
         4'd1, 4'd2, 4'd3: r = OFF_NEG;
         4'd6, 4'd7, 4'd8: r = OFF_POS;
         default:          r = OFF_ZERO;
      endcase
      return r;
   endfunction

   function automatic offset_type nb_dy(input logic [STEP_W-1:0] step);
      offset_type r;
      case (step)
         4'd1, 4'd4, 4'd6: r = OFF_NEG;
         4'd3, 4'd5, 4'd8: r = OFF_POS;
         default:          r = OFF_ZERO;
      endcase
      return r;
   endfunction

   function automatic coord_type apply_off(input coord_type base, input coord_type stride,
                                           input offset_type off);
      coord_type r;
      case (off)
         OFF_NEG: r = base - stride;
         OFF_POS: r = base + stride;
         default: r = base;
      endcase
      return r;
   endfunction

   function automatic logic in_bounds(input coord_type x, input coord_type y,
                                      input logic [RES_W-1:0] w, input logic [RES_W-1:0] h);
      return !x[COORD_W-1] && !y[COORD_W-1] &&
             (x[COORD_W-2:0] < {1'b0, w}) && (y[COORD_W-2:0] < {1'b0, h});
   endfunction

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

>>> rtl/fbmd_seq.sv
// Sequencer: takes items, walks fills and neighbor reads, drives the store port.
module fbmd_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [7:0]                  req_pos_x,
   input  logic [7:0]                  req_pos_y,
   input  logic [8:0]                  req_block_edge,
   input  logic [7:0]                  req_red_in,
   input  logic [7:0]                  req_green_in,
   input  logic [7:0]                  req_blue_in,
   input  logic [fbmd_pkg::RES_W-1:0]  eff_width,
   input  logic [fbmd_pkg::RES_W-1:0]  eff_height,
   input  logic                        slot_free,
   output fbmd_pkg::mem_req_type       mem_req,
   output fbmd_pkg::ctl_type           ctl
);
   import fbmd_pkg::*;

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [7:0]           x_ff, x_in, y_ff, y_in;
   logic [8:0]           edge_ff, edge_in;
   logic [PIXEL_W-1:0]   color_ff, color_in;
   logic [8:0]           col_ff, col_in, row_ff, row_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rdc_ff, rdc_in, okc_ff, okc_in, rdn_ff, rdn_in;

   coord_type            base_x, base_y, stride, px, py;
   logic                 in_ok, ctr_ok, accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rdc_ff   <= 1'b0;
         rdn_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdc_ff   <= rdc_in;
         rdn_ff   <= rdn_in;
      end
      op_ff    <= op_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      edge_ff  <= edge_in;
      color_ff <= color_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      step_ff  <= step_in;
      okc_ff   <= okc_in;
   end

   // working coordinate of the current store access
   always_comb begin
      base_x = coord_type'({3'b000, x_ff});
      base_y = coord_type'({3'b000, y_ff});
      stride = coord_type'({2'b00, edge_ff});
      case (state_ff)
         ST_FILL: begin
            px = base_x + coord_type'({2'b00, col_ff});
            py = base_y + coord_type'({2'b00, row_ff});
         end
         ST_CTR: begin
            px = apply_off(base_x, stride, nb_dx(step_ff));
            py = apply_off(base_y, stride, nb_dy(step_ff));
         end
         default: begin
            px = base_x;
            py = base_y;
         end
      endcase
      in_ok  = in_bounds(px, py, eff_width, eff_height);
      ctr_ok = in_bounds(base_x, base_y, eff_width, eff_height);
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      edge_in  = edge_ff;
      color_in = color_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      step_in  = step_ff;
      rdc_in   = 1'b0;
      okc_in   = okc_ff;
      rdn_in   = 1'b0;

      mem_req.we    = 1'b0;
      mem_req.re    = 1'b0;
      mem_req.x     = px[RES_W-1:0];
      mem_req.y     = py[RES_W-1:0];
      mem_req.wdata = color_ff;

      ctl.clear      = accept;
      ctl.cap_center = rdc_ff;
      ctl.center_ok  = okc_ff;
      ctl.cap_nb     = rdn_ff;
      ctl.load       = 1'b0;
      ctl.kind       = (op_ff == OP_CONTRAST);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = opcode_type'(req_opcode);
               x_in     = req_pos_x;
               y_in     = req_pos_y;
               color_in = {req_red_in, req_green_in, req_blue_in};
               col_in   = '0;
               row_in   = '0;
               step_in  = '0;
               edge_in  = req_block_edge;
               case (opcode_type'(req_opcode))
                  OP_WRITE: begin
                     // a single write is a fill of edge one
                     edge_in  = 9'd1;
                     state_in = ST_FILL;
                  end
                  OP_FILL: begin
                     state_in = (req_block_edge == 9'd0) ? ST_IDLE : ST_FILL;
                  end
                  OP_READ:  state_in = ST_RD;
                  default:  state_in = ST_CTR;
               endcase
            end
         end
         ST_FILL: begin
            mem_req.we = in_ok;
            if (col_ff == edge_ff - 9'd1) begin
               col_in = '0;
               row_in = row_ff + 9'd1;
               if (row_ff == edge_ff - 9'd1) begin
                  state_in = ST_IDLE;
               end
            end else begin
               col_in = col_ff + 9'd1;
            end
         end
         ST_RD: begin
            mem_req.re = in_ok;
            rdc_in     = 1'b1;
            okc_in     = in_ok;
            state_in   = ST_DRAIN;
         end
         ST_CTR: begin
            // neighbors count only when the center itself is inside
            mem_req.re = ctr_ok && in_ok;
            if (step_ff == '0) begin
               rdc_in = 1'b1;
               okc_in = in_ok;
            end else begin
               rdn_in = ctr_ok && in_ok;
            end
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               ctl.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/fbmd_rsp.sv
// Result path: center pixel, running maximum difference and output register.
module fbmd_rsp (
   input  logic                          clock,
   input  logic                          reset,
   input  fbmd_pkg::ctl_type             ctl,
   input  logic [fbmd_pkg::PIXEL_W-1:0]  rd_data,
   output logic                          slot_free,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_red_out,
   output logic [7:0]                    rsp_green_out,
   output logic [7:0]                    rsp_blue_out,
   output logic [7:0]                    rsp_max_difference,
   output logic                          rsp_answer_kind
);
   import fbmd_pkg::*;

   logic [PIXEL_W-1:0]  center_ff, center_in;
   logic [CHAN_W-1:0]   best_ff, best_in;
   logic                valid_ff, valid_in;
   logic [PIXEL_W-1:0]  color_ff, color_in;
   logic [CHAN_W-1:0]   maxd_ff, maxd_in;
   logic                kind_ff, kind_in;
   logic [CHAN_W-1:0]   d_r, d_g, d_b, d_rg, d_top;

   assign slot_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      center_ff <= center_in;
      best_ff   <= best_in;
      color_ff  <= color_in;
      maxd_ff   <= maxd_in;
      kind_ff   <= kind_in;
   end

   always_comb begin
      d_r   = abs_diff(center_ff[23:16], rd_data[23:16]);
      d_g   = abs_diff(center_ff[15:8], rd_data[15:8]);
      d_b   = abs_diff(center_ff[7:0], rd_data[7:0]);
      d_rg  = (d_r > d_g) ? d_r : d_g;
      d_top = (d_rg > d_b) ? d_rg : d_b;

      center_in = center_ff;
      best_in   = best_ff;
      if (ctl.clear) begin
         best_in = '0;
      end else if (ctl.cap_center) begin
         center_in = ctl.center_ok ? rd_data : '0;
      end else if (ctl.cap_nb && (d_top > best_ff)) begin
         best_in = d_top;
      end

      valid_in = valid_ff && rsp_stall;
      color_in = color_ff;
      maxd_in  = maxd_ff;
      kind_in  = kind_ff;
      if (ctl.load) begin
         valid_in = 1'b1;
         kind_in  = ctl.kind;
         color_in = ctl.kind ? '0 : center_ff;
         maxd_in  = ctl.kind ? best_ff : '0;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_red_out        = color_ff[23:16];
   assign rsp_green_out      = color_ff[15:8];
   assign rsp_blue_out       = color_ff[7:0];
   assign rsp_max_difference = maxd_ff;
   assign rsp_answer_kind    = kind_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (!valid_ff || !rsp_stall))
      else $error("result loaded over a waiting item");

   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (kind_ff ? (color_ff == '0) : (maxd_ff == '0)))
      else $error("result fields do not match answer kind");

   a_stage_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.cap_center && ctl.cap_nb))
      else $error("center and neighbor data captured together");

endmodule

>>> rtl/frame_store_block_fill_max_diff_core.sv
// Top level: pixel frame store with block fill and neighbor contrast.
// One single-port RAM of MAX_WIDTH*MAX_HEIGHT 24-bit pixels (red, green, blue) holds the frame;
// every operation goes through its one port, one access per cycle, so item time follows the
// number of pixels it visits: a pixel write or a read visits one, a fill of edge E visits E*E
// (edge 0 none) and a contrast request the center plus eight neighbors; a read or contrast
// request then passes a drain state and a posting state. Results sit in an output register,
// so a waiting result does not hold off the next item; a new result waits only for that
// register. Pixels are undefined after reset until written; there is no clearing pass.
module frame_store_block_fill_max_diff_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [8:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [8:0]  req_block_edge,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_max_difference,
   output logic        rsp_answer_kind
);
   import fbmd_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = AW + RES_W + 1;

   logic [RES_W-1:0]    width_ff, width_in, height_ff, height_in;
   logic [RES_W-1:0]    eff_width, eff_height;
   mem_req_type         mem_req;
   ctl_type             ctl;
   logic                slot_free;
   logic [AW-1:0]       addr;
   logic [PW-1:0]       addr_wide;
   logic [PIXEL_W-1:0]  rd_data_ff;
   logic [PIXEL_W-1:0]  mem [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_write_data;
            CSR_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
      // resolution in use is the register clamped to the store size
      eff_width  = (13'(width_ff) < 13'(MAX_WIDTH)) ? width_ff : RES_W'(MAX_WIDTH);
      eff_height = (13'(height_ff) < 13'(MAX_HEIGHT)) ? height_ff : RES_W'(MAX_HEIGHT);
   end

   // row-major address; coordinates are in bounds whenever the port is used
   assign addr_wide = PW'(mem_req.y) * PW'(MAX_WIDTH) + PW'(mem_req.x);
   assign addr      = addr_wide[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= mem[addr];
      end
   end

   fbmd_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_block_edge (req_block_edge),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .eff_width      (eff_width),
      .eff_height     (eff_height),
      .slot_free      (slot_free),
      .mem_req        (mem_req),
      .ctl            (ctl)
   );

   fbmd_rsp u_rsp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .rd_data            (rd_data_ff),
      .slot_free          (slot_free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red_out        (rsp_red_out),
      .rsp_green_out      (rsp_green_out),
      .rsp_blue_out       (rsp_blue_out),
      .rsp_max_difference (rsp_max_difference),
      .rsp_answer_kind    (rsp_answer_kind)
   );

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && mem_req.re))
      else $error("read and write on the single port in one cycle");

   a_wr_bounds: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (mem_req.x < eff_width && mem_req.y < eff_height))
      else $error("store write outside the resolution in use");

   a_rd_bounds: assert property (@(posedge clock) disable iff (reset)
      mem_req.re |-> (mem_req.x < eff_width && mem_req.y < eff_height))
      else $error("store read outside the resolution in use");

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (mem_req.we || mem_req.re) |-> req_stall)
      else $error("item taken while the store port is busy");

endmodule

>>> dv/fbmd_checker.sv
// Frame store checker: mirrors the frame and resolution, predicts each answer and compares it.
`timescale 1ns / 1ps
module fbmd_checker #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [8:0]  csr_write_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [8:0]  req_block_edge,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_red_out,
   input  logic [7:0]  rsp_green_out,
   input  logic [7:0]  rsp_blue_out,
   input  logic [7:0]  rsp_max_difference,
   input  logic        rsp_answer_kind,
   output int          mismatch_count,
   output int          outstanding
);
   import fbmd_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] max_diff;
      logic              kind;
   } frame_answer_type;

   logic [PIXEL_W-1:0] frame_mem [MAX_WIDTH*MAX_HEIGHT];
   logic [RES_W-1:0]   width_reg;
   logic [RES_W-1:0]   height_reg;
   frame_answer_type   pending_answers[$];

   function automatic bit in_frame(input int x, input int y);
      int w;
      int h;
      w = int'(width_reg);
      h = int'(height_reg);
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return x >= 0 && y >= 0 && x < w && y < h;
   endfunction

   // largest channel difference to the eight neighbors at the given stride
   function automatic logic [CHAN_W-1:0] neighbor_contrast(input int x, input int y,
                                                           input int span);
      logic [PIXEL_W-1:0] c;
      logic [PIXEL_W-1:0] n;
      int best;
      int a;
      int b;
      int nx;
      int ny;
      best = 0;
      if (in_frame(x, y)) begin
         c = frame_mem[y*MAX_WIDTH + x];
         for (int i = -1; i <= 1; i++) begin
            for (int j = -1; j <= 1; j++) begin
               nx = x + i*span;
               ny = y + j*span;
               if ((i != 0 || j != 0) && in_frame(nx, ny)) begin
                  n = frame_mem[ny*MAX_WIDTH + nx];
                  for (int k = 0; k < PIXEL_W; k += CHAN_W) begin
                     a = int'(c[k +: CHAN_W]);
                     b = int'(n[k +: CHAN_W]);
                     if (a - b > best) best = a - b;
                     if (b - a > best) best = b - a;
                  end
               end
            end
         end
      end
      return best[CHAN_W-1:0];
   endfunction

   always @(posedge clock) begin : track
      frame_answer_type   got;
      frame_answer_type   want;
      logic [PIXEL_W-1:0] colour;
      logic [PIXEL_W-1:0] pix;
      int                 x;
      int                 y;
      int                 span;
      if (reset) begin
         width_reg = 9'd256;
         height_reg = 9'd256;
         pending_answers.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_WIDTH) width_reg = csr_write_data;
            else height_reg = csr_write_data;
         end
         // answers first: one leaving at this edge never belongs to an item taken at it
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_red_out, rsp_green_out, rsp_blue_out, rsp_max_difference,
                    rsp_answer_kind};
            if (pending_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected answer: r=%0h g=%0h b=%0h diff=%0h kind=%0b",
                           got.red, got.green, got.blue, got.max_diff, got.kind);
            end else begin
               want = pending_answers.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.max_diff !== want.max_diff ||
                   got.kind !== want.kind) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("answer mismatch: expected r=%0h g=%0h b=%0h diff=%0h kind=%0b, %s",
                              want.red, want.green, want.blue, want.max_diff, want.kind,
                              $sformatf("got r=%0h g=%0h b=%0h diff=%0h kind=%0b",
                                        got.red, got.green, got.blue, got.max_diff,
                                        got.kind));
               end
            end
         end
         if (req_valid && !req_stall) begin
            x = int'(req_pos_x);
            y = int'(req_pos_y);
            span = int'(req_block_edge);
            colour = {req_red_in, req_green_in, req_blue_in};
            case (opcode_type'(req_opcode))
               OP_WRITE: begin
                  if (in_frame(x, y)) frame_mem[y*MAX_WIDTH + x] = colour;
               end
               OP_FILL: begin
                  for (int i = 0; i < span; i++)
                     for (int j = 0; j < span; j++)
                        if (in_frame(x + i, y + j))
                           frame_mem[(y + j)*MAX_WIDTH + x + i] = colour;
               end
               OP_READ: begin
                  pix = in_frame(x, y) ? frame_mem[y*MAX_WIDTH + x] : '0;
                  want = '{pix[23:16], pix[15:8], pix[7:0], 8'd0, 1'b0};
                  pending_answers.push_back(want);
               end
               default: begin
                  want = '{8'd0, 8'd0, 8'd0, neighbor_contrast(x, y, span), 1'b1};
                  pending_answers.push_back(want);
               end
            endcase
         end
      end
      outstanding = pending_answers.size();
   end

endmodule

>>> dv/tb_top.sv
// Testbench top: stimulus, receiver stalls and verdict for the frame store block.
`timescale 1ns / 1ps
module tb_top;
   import fbmd_pkg::*;

   localparam int FRAME_W       = 256;
   localparam int FRAME_H       = 256;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_WIDTH;
   logic [8:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_WRITE;
   logic [7:0]  req_pos_x = '0;
   logic [7:0]  req_pos_y = '0;
   logic [8:0]  req_block_edge = '0;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [7:0]  rsp_max_difference;
   logic        rsp_answer_kind;
   int          mismatch_count;
   int          outstanding;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          res_w = 256;
   int          res_h = 256;
   bit          hold_toggle = 1'b0;
   bit          hold_seen = 1'b0;
   int          hold_left = 0;

   frame_store_block_fill_max_diff_core #(
      .MAX_WIDTH  (FRAME_W),
      .MAX_HEIGHT (FRAME_H)
   ) u_dut (.*);

   fbmd_checker #(
      .MAX_WIDTH  (FRAME_W),
      .MAX_HEIGHT (FRAME_H)
   ) u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when the top asks for one
   always @(negedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic int pick_coord(input int lim);
      int roll;
      int v;
      roll = $urandom_range(99);
      if (lim == 0 || roll >= 90) v = $urandom_range(255);
      else if (roll < 78) v = $urandom_range(lim - 1);
      else v = lim - 2 + $urandom_range(3);   // around the resolution border
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
   endfunction

   function automatic int pick_stride(input int lim);
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) return 0;
      if (roll < 50) return $urandom_range(4, 1);
      if (roll < 80) return $urandom_range((lim < 1) ? 1 : lim, 1);
      return $urandom_range(256);
   endfunction

   function automatic logic [7:0] pick_chan();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return 8'h00;
      if (roll < 20) return 8'hff;
      return 8'($urandom_range(255));
   endfunction

   // entered and left at a falling edge; valid stays up for a following item
   task automatic send_item(input opcode_type op, input logic [7:0] x, input logic [7:0] y,
                            input logic [8:0] span, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pos_x <= x;
      req_pos_y <= y;
      req_block_edge <= span;
      req_red_in <= red;
      req_green_in <= green;
      req_blue_in <= blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_resolution(input int w, input int h);
      csr_write_en <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_write_data <= w[8:0];
      @(negedge clock);
      csr_index <= CSR_HEIGHT;
      csr_write_data <= h[8:0];
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      res_w = w;
      res_h = h;
   endtask

   task automatic start_phase(input int w, input int h, input int send_pct, input int recv_pct);
      set_resolution(w, h);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      @(negedge clock);
   endtask

   // a closing read answers only after all earlier work, so the block is idle after it
   task automatic finish_phase();
      send_item(OP_READ, 8'd0, 8'd0, 9'd0, 8'd0, 8'd0, 8'd0);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_item(input bit answers_heavy);
      int roll;
      int lim_w;
      int lim_h;
      int x;
      int y;
      int span;
      int px;
      int py;
      lim_w = (res_w > FRAME_W) ? FRAME_W : res_w;
      lim_h = (res_h > FRAME_H) ? FRAME_H : res_h;
      x = pick_coord(lim_w);
      y = pick_coord(lim_h);
      roll = $urandom_range(99);
      if (answers_heavy) begin
         case ($urandom_range(3))
            0: send_item(OP_WRITE, 8'(x), 8'(y), 9'($urandom_range(256)), pick_chan(),
                         pick_chan(), pick_chan());
            1: send_item(OP_READ, 8'(x), 8'(y), 9'($urandom_range(256)), pick_chan(),
                         pick_chan(), pick_chan());
            default: send_item(OP_CONTRAST, 8'(x), 8'(y),
                               9'(pick_stride(lim_w > lim_h ? lim_w : lim_h)),
                               pick_chan(), pick_chan(), pick_chan());
         endcase
      end else if (roll < 10) begin
         // paint a center and its eight neighbors, then ask for their contrast
         span = pick_stride(lim_w > lim_h ? lim_w : lim_h);
         for (int i = -1; i <= 1; i++) begin
            for (int j = -1; j <= 1; j++) begin
               px = x + i*span;
               py = y + j*span;
               if (px >= 0 && px < FRAME_W && py >= 0 && py < FRAME_H && (span != 0 || i == 0))
                  send_item(OP_WRITE, 8'(px), 8'(py), 9'($urandom_range(256)), pick_chan(),
                            pick_chan(), pick_chan());
            end
         end
         send_item(OP_CONTRAST, 8'(x), 8'(y), 9'(span), pick_chan(), pick_chan(), pick_chan());
      end else if (roll < 32) begin
         send_item(OP_WRITE, 8'(x), 8'(y), 9'($urandom_range(256)), pick_chan(), pick_chan(),
                   pick_chan());
      end else if (roll < 54) begin
         send_item(OP_READ, 8'(x), 8'(y), 9'($urandom_range(256)), pick_chan(), pick_chan(),
                   pick_chan());
      end else if (roll < 72) begin
         // fills stay small, with the odd large one
         roll = $urandom_range(99);
         if (roll < 5) span = 0;
         else if (roll < 85) span = $urandom_range(8, 1);
         else if (roll < 97) span = $urandom_range(32, 9);
         else span = $urandom_range(64, 33);
         send_item(OP_FILL, 8'(x), 8'(y), 9'(span), pick_chan(), pick_chan(), pick_chan());
      end else begin
         send_item(OP_CONTRAST, 8'(x), 8'(y), 9'(pick_stride(lim_w > lim_h ? lim_w : lim_h)),
                   pick_chan(), pick_chan(), pick_chan());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      start_phase(256, 256, 0, 0);

      // paint the whole frame once so no pixel is read before it is written
      send_item(OP_FILL, 8'd0, 8'd0, 9'd256, 8'h40, 8'h80, 8'hc0);
      send_item(OP_WRITE, 8'd0, 8'd0, 9'd0, 8'hff, 8'h00, 8'h80);
      send_item(OP_WRITE, 8'd255, 8'd255, 9'd1, 8'h00, 8'hff, 8'h7f);
      send_item(OP_WRITE, 8'd255, 8'd0, 9'd256, 8'h01, 8'hfe, 8'h00);
      send_item(OP_WRITE, 8'd0, 8'd255, 9'd511, 8'h80, 8'h7f, 8'hff);
      send_item(OP_READ, 8'd0, 8'd0, 9'd0, 8'h00, 8'h00, 8'h00);
      send_item(OP_READ, 8'd255, 8'd255, 9'd0, 8'hff, 8'hff, 8'hff);
      send_item(OP_CONTRAST, 8'd0, 8'd0, 9'd1, 8'h00, 8'h00, 8'h00);
      send_item(OP_CONTRAST, 8'd255, 8'd255, 9'd255, 8'h00, 8'h00, 8'h00);
      send_item(OP_CONTRAST, 8'd128, 8'd128, 9'd128, 8'h00, 8'h00, 8'h00);
      send_item(OP_CONTRAST, 8'd128, 8'd128, 9'd0, 8'h00, 8'h00, 8'h00);
      send_item(OP_CONTRAST, 8'd10, 8'd10, 9'd256, 8'h00, 8'h00, 8'h00);
      // block running off the far corner is clipped
      send_item(OP_FILL, 8'd250, 8'd250, 9'd16, 8'hee, 8'h11, 8'h22);
      send_item(OP_FILL, 8'd5, 8'd5, 9'd0, 8'hff, 8'hff, 8'hff);
      send_item(OP_READ, 8'd252, 8'd253, 9'd0, 8'h00, 8'h00, 8'h00);
      send_item(OP_CONTRAST, 8'd255, 8'd255, 9'd5, 8'h00, 8'h00, 8'h00);
      finish_phase();

      start_phase(100, 60, 0, 0);
      send_item(OP_WRITE, 8'd150, 8'd10, 9'd0, 8'h12, 8'h34, 8'h56);
      send_item(OP_READ, 8'd150, 8'd10, 9'd0, 8'h00, 8'h00, 8'h00);
      send_item(OP_CONTRAST, 8'd150, 8'd10, 9'd1, 8'h00, 8'h00, 8'h00);
      send_item(OP_FILL, 8'd120, 8'd70, 9'd5, 8'h99, 8'h99, 8'h99);
      send_item(OP_FILL, 8'd98, 8'd58, 9'd4, 8'h0f, 8'hf0, 8'h5a);
      send_item(OP_READ, 8'd99, 8'd59, 9'd0, 8'h00, 8'h00, 8'h00);
      send_item(OP_CONTRAST, 8'd99, 8'd59, 9'd1, 8'h00, 8'h00, 8'h00);
      finish_phase();

      // zero resolution: nothing is inside
      start_phase(0, 0, 0, 0);
      send_item(OP_WRITE, 8'd0, 8'd0, 9'd0, 8'h55, 8'h55, 8'h55);
      send_item(OP_READ, 8'd0, 8'd0, 9'd0, 8'h00, 8'h00, 8'h00);
      send_item(OP_CONTRAST, 8'd0, 8'd0, 9'd1, 8'h00, 8'h00, 8'h00);
      finish_phase();

      start_phase(256, 256, 0, 0);
      repeat (160) random_item(1'b0);
      finish_phase();
      start_phase(16, 16, 54, 0);
      repeat (120) random_item(1'b0);
      finish_phase();
      start_phase(200, 256, 0, 54);
      repeat (120) random_item(1'b0);
      finish_phase();
      start_phase(1, 256, 14, 14);
      repeat (95) random_item(1'b0);
      finish_phase();
      start_phase(37, 91, 0, 0);
      repeat (105) random_item(1'b0);
      finish_phase();

      // long receiver hold-off while the sender keeps offering items
      start_phase(256, 256, 0, 0);
      @(posedge clock);
      hold_toggle = ~hold_toggle;
      @(negedge clock);
      repeat (140) random_item(1'b1);
      finish_phase();

      // register above the frame size clamps to it
      start_phase(300, 8, 54, 54);
      repeat (95) random_item(1'b0);
      finish_phase();
      start_phase(256, 1, 14, 14);
      repeat (70) random_item(1'b0);
      finish_phase();
      start_phase(0, 256, 0, 0);
      repeat (35) random_item(1'b0);
      finish_phase();

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #16_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
